// ===== src/isf_pkg.sv =====
package isf_pkg;

  localparam int PIX_W     = 8;
  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [REG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  // Input command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0]        PIX_FULL    = 8'd255;
  localparam logic signed [SUM_W-1:0] SUM_PIX_MAX = 12'sd255;
  localparam logic signed [SUM_W-1:0] CENTRE_GAIN = 12'sd5;

  // One classified request handed from the front end to the filter back end.
  typedef struct packed {
    logic             produce;
    logic             write_en;
    logic             centre_bank;
    logic             first_col;
    logic             has_right;
    logic             top_valid;
    logic             plane_end;
    logic [PIX_W-1:0] bottom;
  } isf_op_t;

endpackage

// ===== src/isf_front.sv =====
module isf_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [isf_pkg::PIX_W-1:0]           s_tdata,   // [7:0] pixel_in
  input  logic                                s_tuser,   // [0] command
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [isf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [isf_pkg::REG_W-1:0]           cfg_data,
  input  logic                                q_ready,
  output logic                                q_push,
  output logic [$clog2(MAX_WIDTH)-1:0]        q_x,
  output isf_pkg::isf_op_t                    q_op
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = (($clog2(MAX_WIDTH + 1) > isf_pkg::REG_W) ?
                        $clog2(MAX_WIDTH + 1) : isf_pkg::REG_W) + 1;
  localparam int HCW = (($clog2(MAX_HEIGHT + 1) > isf_pkg::REG_W) ?
                        $clog2(MAX_HEIGHT + 1) : isf_pkg::REG_W) + 1;

  logic [isf_pkg::REG_W-1:0] frame_width;
  logic [isf_pkg::REG_W-1:0] frame_height;
  logic [XW-1:0]             column_count;
  logic [YW-1:0]             row_count;
  logic                      draining;

  logic [WCW-1:0] width_ext, width_used;
  logic [HCW-1:0] height_ext, height_used;
  logic           last_col, last_row;
  logic           in_accept, is_pixel, take_pixel, take_drain;
  logic           cfg_write;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_ready;
  assign in_accept = s_tvalid && s_tready;
  assign is_pixel  = (s_tuser == isf_pkg::CMD_PIXEL);
  assign take_pixel = in_accept && is_pixel && !draining;
  assign take_drain = in_accept && (s_tuser == isf_pkg::CMD_DRAIN) && draining;
  assign cfg_write = cfg_valid && cfg_ready &&
                     ((cfg_index == isf_pkg::REG_FRAME_WIDTH) ||
                      (cfg_index == isf_pkg::REG_FRAME_HEIGHT));

  // Register values out of range are clamped to 1..maximum.
  always_comb begin
    width_ext  = WCW'(frame_width);
    height_ext = HCW'(frame_height);
    if (width_ext == '0) begin
      width_used = WCW'(1);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      width_used = WCW'(MAX_WIDTH);
    end else begin
      width_used = width_ext;
    end
    if (height_ext == '0) begin
      height_used = HCW'(1);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      height_used = HCW'(MAX_HEIGHT);
    end else begin
      height_used = height_ext;
    end
  end

  assign last_col = ((WCW'(column_count) + WCW'(1)) == width_used);
  assign last_row = ((HCW'(row_count) + HCW'(1)) == height_used);

  // A pixel writes its inverted value into the bank opposite the centre row and
  // produces the output one row above it; a drain produces from the last row.
  always_comb begin
    q_push = take_pixel || take_drain;
    q_x    = column_count;
    q_op   = '0;
    q_op.first_col = (column_count == '0);
    q_op.has_right = !last_col;
    if (take_pixel) begin
      q_op.produce     = (row_count != '0);
      q_op.write_en    = 1'b1;
      q_op.centre_bank = ~row_count[0];
      q_op.top_valid   = (row_count > YW'(1));
      q_op.bottom      = isf_pkg::PIX_FULL - s_tdata;
    end else begin
      q_op.produce     = 1'b1;
      q_op.centre_bank = row_count[0];
      q_op.top_valid   = (row_count != '0);
      q_op.plane_end   = last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= isf_pkg::RESET_FRAME_WIDTH;
      frame_height <= isf_pkg::RESET_FRAME_HEIGHT;
      column_count <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == isf_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
      column_count <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (take_pixel) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          draining <= 1'b1;
        end else begin
          row_count <= row_count + YW'(1);
        end
      end else begin
        column_count <= column_count + XW'(1);
      end
    end else if (take_drain) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= '0;
        draining     <= 1'b0;
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

endmodule

// ===== src/isf_queue.sv =====
module isf_queue #(
  parameter int DATA_W = 20,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PW-1:0]     head, tail;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[head];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/isf_line_bank.sv =====
module isf_line_bank #(
  parameter int DEPTH = 2048
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [isf_pkg::PIX_W-1:0]      wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_b,
  output logic [isf_pkg::PIX_W-1:0]      rd_data_a,
  output logic [isf_pkg::PIX_W-1:0]      rd_data_b
);

  logic [isf_pkg::PIX_W-1:0] mem [DEPTH];

  // Reads return the value held before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== src/isf_back.sv =====
module isf_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]    q_x,
  input  isf_pkg::isf_op_t                q_op,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [isf_pkg::PIX_W-1:0]       m_tdata,   // [7:0] pixel_out
  output logic                            m_tlast    // plane_end
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int SW = isf_pkg::SUM_W;

  logic                      advance;
  logic [XW-1:0]             addr_b;
  logic                      wr_bank0, wr_bank1;
  logic [isf_pkg::PIX_W-1:0] b0_a, b0_b, b1_a, b1_b;

  logic                      s1_valid;
  isf_pkg::isf_op_t          s1_op;
  logic [isf_pkg::PIX_W-1:0] left_pix;

  logic [isf_pkg::PIX_W-1:0] centre, right, top, left;
  logic signed [SW-1:0]      sum;
  logic [isf_pkg::PIX_W-1:0] clamped;

  // The whole back end moves whenever the output register can take a value.
  assign advance = !(m_tvalid && !m_tready);
  assign q_pop   = q_valid && advance;
  assign addr_b  = q_op.has_right ? q_x + XW'(1) : q_x;

  // New pixels always go to the bank opposite the centre row.
  assign wr_bank0 = q_pop && q_op.write_en && q_op.centre_bank;
  assign wr_bank1 = q_pop && q_op.write_en && !q_op.centre_bank;

  isf_line_bank #(.DEPTH(MAX_WIDTH)) u_bank0 (
    .clk       (clk),
    .wr_en     (wr_bank0),
    .wr_addr   (q_x),
    .wr_data   (q_op.bottom),
    .rd_en     (q_pop),
    .rd_addr_a (q_x),
    .rd_addr_b (addr_b),
    .rd_data_a (b0_a),
    .rd_data_b (b0_b)
  );

  isf_line_bank #(.DEPTH(MAX_WIDTH)) u_bank1 (
    .clk       (clk),
    .wr_en     (wr_bank1),
    .wr_addr   (q_x),
    .wr_data   (q_op.bottom),
    .rd_en     (q_pop),
    .rd_addr_a (q_x),
    .rd_addr_b (addr_b),
    .rd_data_a (b1_a),
    .rd_data_b (b1_b)
  );

  always_comb begin
    centre = s1_op.centre_bank ? b1_a : b0_a;
    right  = s1_op.has_right ? (s1_op.centre_bank ? b1_b : b0_b) : '0;
    top    = s1_op.top_valid ? (s1_op.centre_bank ? b0_a : b1_a) : '0;
    left   = s1_op.first_col ? '0 : left_pix;
    sum    = signed'(SW'(centre)) * isf_pkg::CENTRE_GAIN
           - signed'(SW'(top)) - signed'(SW'(s1_op.bottom))
           - signed'(SW'(left)) - signed'(SW'(right));
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > isf_pkg::SUM_PIX_MAX) begin
      clamped = isf_pkg::PIX_FULL;
    end else begin
      clamped = sum[isf_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_pop;
      m_tvalid <= s1_valid && s1_op.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op <= q_op;
      if (s1_valid && s1_op.produce) begin
        left_pix <= centre;
        m_tdata  <= clamped;
        m_tlast  <= s1_op.plane_end;
      end
    end
  end

endmodule

// ===== src/invert_sharpen_filter_core.sv =====
// Inverts 8-bit pixels of one plane (255 minus value), applies a cross sharpen
// kernel (five times centre minus the four neighbours, outside pixels read as
// zero) and clamps to 0..255. Output runs one row behind input; after the last
// pixel of a plane, frame_width drain requests (tuser = 1) release the final
// row, with tlast on its last pixel. Requests out of phase are dropped. The
// block takes one request per clock while the queue has room: a front end
// classifies requests and tracks position, a four-entry queue decouples it
// from the back end, which reads two line banks of MAX_WIDTH bytes (two read
// ports each). A request goes through the queue, the bank read registers and
// the output register. Line banks need no clearing. A configuration write
// restarts the plane; the user, not the block, must ensure the block is idle.
module invert_sharpen_filter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [isf_pkg::PIX_W-1:0]       s_tdata,    // [7:0] pixel_in
  input  logic                            s_tuser,    // [0] command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [isf_pkg::PIX_W-1:0]       m_tdata,    // [7:0] pixel_out
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [isf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isf_pkg::REG_W-1:0]       cfg_data
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int OPW    = $bits(isf_pkg::isf_op_t);
  localparam int QW     = XW + OPW;
  localparam int QDEPTH = 4;

  logic             f_push, q_ready, q_valid, q_pop;
  logic [XW-1:0]    f_x, q_x;
  isf_pkg::isf_op_t f_op, q_op;
  logic [QW-1:0]    q_out;

  isf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .q_push    (f_push),
    .q_x       (f_x),
    .q_op      (f_op)
  );

  isf_queue #(.DATA_W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  ({f_x, f_op}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  assign q_x  = q_out[QW-1:OPW];
  assign q_op = q_out[OPW-1:0];

  isf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_x      (q_x),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
